@@ rtl/core/pge_pkg.sv @@
// ----------------------------------------------------------------------------
// pge_pkg
// Shared widths, codes and saturation helpers for the point gravity stepper.
// ----------------------------------------------------------------------------
package pge_pkg;

  localparam int POS_W      = 44;
  localparam int VEL_W      = 45;
  localparam int CFG_W      = 52;
  localparam int GM_W       = 52;
  localparam int STEP_W     = 25;
  localparam int REST_W     = 17;
  localparam int REST_BITS  = 16;
  localparam int TIME_BITS  = 24;
  localparam int WW         = 192;
  localparam int MB_W       = 64;
  localparam int DIV_CNT_W  = 8;
  localparam int QUO_W      = 47;

  typedef enum logic [2:0] {
    REG_ATT_X   = 3'd0,
    REG_ATT_Y   = 3'd1,
    REG_ATT_Z   = 3'd2,
    REG_GM      = 3'd3,
    REG_STEP    = 3'd4,
    REG_SURFACE = 3'd5,
    REG_REST    = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  localparam logic signed [63:0] VEL_MAX64 = 64'sd17592186044415;
  localparam logic signed [63:0] VEL_MIN64 = -64'sd17592186044416;
  localparam logic signed [63:0] POS_MAX64 = 64'sd8796093022207;
  localparam logic signed [63:0] POS_MIN64 = -64'sd8796093022208;

  function automatic logic vel_ovf(input logic signed [63:0] x);
    return (x > VEL_MAX64) || (x < VEL_MIN64);
  endfunction

  function automatic logic [VEL_W-1:0] vel_sat(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x;
    if (x > VEL_MAX64) y = VEL_MAX64;
    if (x < VEL_MIN64) y = VEL_MIN64;
    return y[VEL_W-1:0];
  endfunction

  function automatic logic pos_ovf(input logic signed [63:0] x);
    return (x > POS_MAX64) || (x < POS_MIN64);
  endfunction

  function automatic logic [POS_W-1:0] pos_sat(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x;
    if (x > POS_MAX64) y = POS_MAX64;
    if (x < POS_MIN64) y = POS_MIN64;
    return y[POS_W-1:0];
  endfunction

endpackage

@@ rtl/core/pge_channels.sv @@
// ----------------------------------------------------------------------------
// pge channels
// Valid/ready channels for the body command beats and the state result beats.
// ----------------------------------------------------------------------------
interface pge_in_if import pge_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic signed [POS_W-1:0] load_pos_x;
  logic signed [POS_W-1:0] load_pos_y;
  logic signed [POS_W-1:0] load_pos_z;
  logic signed [VEL_W-1:0] load_vel_x;
  logic signed [VEL_W-1:0] load_vel_y;
  logic signed [VEL_W-1:0] load_vel_z;

  modport source (output valid, operation, load_pos_x, load_pos_y, load_pos_z,
                  load_vel_x, load_vel_y, load_vel_z, input ready);
  modport sink (input valid, operation, load_pos_x, load_pos_y, load_pos_z,
                load_vel_x, load_vel_y, load_vel_z, output ready);
endinterface

interface pge_out_if import pge_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] vel_z;
  logic                    bounced;
  logic                    degenerate;
  logic                    saturated;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  bounced, degenerate, saturated, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                bounced, degenerate, saturated, output ready);
endinterface

@@ rtl/core/pge_mul.sv @@
// ----------------------------------------------------------------------------
// pge_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pge_mul import pge_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [WW-1:0]   a,
  input  logic [MB_W-1:0] b,
  output logic            done,
  output logic [WW-1:0]   prod
);

  logic            busy;
  logic [WW-1:0]   acc;
  logic [WW-1:0]   ma;
  logic [MB_W-1:0] mb;

  // The run ends as soon as no multiplier bits are left.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      acc  <= '0;
      ma   <= a;
      mb   <= b;
    end else if (busy) begin
      if (mb == '0) begin
        busy <= 1'b0;
      end else begin
        if (mb[0]) acc <= acc + ma;
        ma <= ma << 1;
        mb <= mb >> 1;
      end
    end
  end

  assign done = busy && (mb == '0);
  assign prod = acc;

endmodule

@@ rtl/core/pge_div.sv @@
// ----------------------------------------------------------------------------
// pge_div
// Restoring divider, one quotient bit per cycle, quotient capped at 2^46.
// ----------------------------------------------------------------------------
module pge_div import pge_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WW-1:0]    num,
  input  logic [WW-1:0]    den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam logic [QUO_W:0] CAP = (QUO_W+1)'(1) << (QUO_W - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WW-1:0]        ns;
  logic [WW-1:0]        rem;
  logic [QUO_W:0]       qreg;
  logic                 big;
  logic [WW:0]          trial;
  logic                 ge;

  assign trial = {rem, ns[WW-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(WW);
      ns   <= num;
      rem  <= '0;
      qreg <= '0;
      big  <= 1'b0;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        rem  <= ge ? WW'(trial - {1'b0, den}) : trial[WW-1:0];
        ns   <= ns << 1;
        // Bits pushed out of the top mean the quotient is far beyond the cap.
        big  <= big | qreg[QUO_W];
        qreg <= {qreg[QUO_W-1:0], ge};
        cnt  <= cnt - 1'b1;
      end
    end
  end

  assign done = busy && (cnt == '0);
  assign quo  = (big || qreg > CAP) ? CAP[QUO_W-1:0] : qreg[QUO_W-1:0];

endmodule

@@ rtl/core/point_gravity_euler_step.sv @@
// ----------------------------------------------------------------------------
// point_gravity_euler_step
// One body under a fixed attractor, one semi-implicit Euler step per tick.
// ----------------------------------------------------------------------------
// A load beat goes from idle straight to publish. A tick beat with a
// nonzero distance runs three restoring divisions and 11 or 12 multiplier
// products (the twelfth on a bounce). One beat is worked on at a time; the
// next is taken while the last result still waits in the output register.
// Reset (synchronous) restores the default attractor registers and the body
// state (at rest, 6371100 m up), and empties the output register.
module point_gravity_euler_step import pge_pkg::*; #(
  parameter int POSITION_FRACTION_BITS = 16,
  parameter int VELOCITY_FRACTION_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  pge_in_if.sink           item,
  pge_out_if.source        result
);

  localparam int PF = POSITION_FRACTION_BITS;
  localparam int VF = VELOCITY_FRACTION_BITS;
  localparam int NUM_SHIFT = 2 * PF + VF - TIME_BITS;
  localparam int POS_SHIFT = TIME_BITS + VF - PF;

  localparam logic [63:0] ATT_X_RAW = 64'd1000 << PF;
  localparam logic [63:0] SURF_RAW  = 64'd6371000 << PF;
  localparam logic [63:0] BODY_RAW  = 64'd6371100 << PF;
  localparam logic [63:0] PMAX      = 64'd8796093022207;
  localparam logic [POS_W-1:0] ATT_X_RST = POS_W'((ATT_X_RAW > PMAX) ? PMAX : ATT_X_RAW);
  localparam logic [POS_W-1:0] SURF_RST  = POS_W'((SURF_RAW > PMAX) ? PMAX : SURF_RAW);
  localparam logic [POS_W-1:0] BODY_RST  = POS_W'((BODY_RAW > PMAX) ? PMAX : BODY_RAW);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_DEN, S_GT, S_NUM, S_DIV, S_POS, S_BNC, S_FINISH, S_PUBLISH
  } state_t;

  state_t state;
  logic   launched;

  logic signed [POS_W-1:0] att [3];
  logic [GM_W-1:0]         gm;
  logic [STEP_W-1:0]       tstep;
  logic signed [POS_W-1:0] surf;
  logic [REST_W-1:0]       rest;

  logic signed [POS_W-1:0] pos [3];
  logic signed [VEL_W-1:0] vel [3];
  logic signed [POS_W-1:0] np [3];
  logic signed [VEL_W-1:0] nv [3];
  logic [VEL_W-1:0]        m [3];
  logic                    dneg [3];
  logic [VEL_W:0]          l1;
  logic [1:0]              idx;
  logic [WW-1:0]           den;
  logic [WW-1:0]           gt;
  logic [WW-1:0]           num;
  logic                    flag_b, flag_d, flag_s;

  logic                    rv;
  logic signed [POS_W-1:0] out_pos [3];
  logic signed [VEL_W-1:0] out_vel [3];
  logic                    out_b, out_d, out_s;

  logic [VEL_W-1:0] dc [3];
  logic [VEL_W-1:0] mc [3];
  logic [VEL_W:0]   l1c;
  logic [VEL_W-1:0] absnv;

  logic            mul_start, mul_done;
  logic [WW-1:0]   mul_a, mul_p;
  logic [MB_W-1:0] mul_b;
  logic            div_start, div_done;
  logic [QUO_W-1:0] div_q;

  logic signed [63:0] vsum, psum, bval;
  logic [WW-1:0]      pshift;
  logic [63:0]        dp, pr;

  always_comb begin
    l1c = '0;
    for (int i = 0; i < 3; i++) begin
      dc[i] = VEL_W'({att[i][POS_W-1], att[i]} - {pos[i][POS_W-1], pos[i]});
      mc[i] = dc[i][VEL_W-1] ? VEL_W'(~dc[i] + 1'b1) : dc[i];
      l1c   = l1c + {1'b0, mc[i]};
    end
  end

  assign absnv = nv[idx][VEL_W-1] ? VEL_W'(~nv[idx] + 1'b1) : nv[idx];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ: begin
        mul_a = {{(WW-VEL_W){1'b0}}, m[idx]};
        mul_b = {{(MB_W-VEL_W){1'b0}}, m[idx]};
      end
      S_DEN: begin
        mul_a = den;
        mul_b = {{(MB_W-VEL_W-1){1'b0}}, l1};
      end
      S_GT: begin
        mul_a = {{(WW-GM_W){1'b0}}, gm};
        mul_b = {{(MB_W-STEP_W){1'b0}}, tstep};
      end
      S_NUM: begin
        mul_a = gt;
        mul_b = {{(MB_W-VEL_W){1'b0}}, m[idx]};
      end
      S_POS: begin
        mul_a = {{(WW-VEL_W){1'b0}}, absnv};
        mul_b = {{(MB_W-STEP_W){1'b0}}, tstep};
      end
      S_BNC: begin
        mul_a = {{(WW-VEL_W){1'b0}}, absnv};
        mul_b = {{(MB_W-REST_W){1'b0}}, rest};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start = !launched && (state == S_SQ || state == S_DEN || state == S_GT ||
                                   state == S_NUM || state == S_POS || state == S_BNC);
  assign div_start = !launched && (state == S_DIV);

  pge_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  pge_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (div_q)
  );

  // Update arithmetic for the three write-back points.
  always_comb begin
    vsum = 64'(vel[idx]) + (dneg[idx] ? -$signed({17'b0, div_q}) : $signed({17'b0, div_q}));
    pshift = mul_p >> POS_SHIFT;
    dp = {5'b0, pshift[58:0]};
    psum = 64'(pos[idx]) + (nv[idx][VEL_W-1] ? -$signed(dp) : $signed(dp));
    pr = {18'b0, mul_p[REST_BITS +: 46]};
    bval = nv[1][VEL_W-1] ? $signed(pr) : -$signed(pr);
  end

  assign item.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launched <= 1'b0;
      rv       <= 1'b0;
      att[0]   <= ATT_X_RST;
      att[1]   <= '0;
      att[2]   <= '0;
      gm       <= GM_W'(52'd398576057600000);
      tstep    <= STEP_W'(25'd335544);
      surf     <= SURF_RST;
      rest     <= REST_W'(17'd58982);
      pos[0]   <= '0;
      pos[1]   <= BODY_RST;
      pos[2]   <= '0;
      vel[0]   <= '0;
      vel[1]   <= '0;
      vel[2]   <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_ATT_X:   att[0] <= cfg_data[POS_W-1:0];
          REG_ATT_Y:   att[1] <= cfg_data[POS_W-1:0];
          REG_ATT_Z:   att[2] <= cfg_data[POS_W-1:0];
          REG_GM:      gm     <= cfg_data[GM_W-1:0];
          REG_STEP:    tstep  <= cfg_data[STEP_W-1:0];
          REG_SURFACE: surf   <= cfg_data[POS_W-1:0];
          REG_REST:    rest   <= cfg_data[REST_W-1:0];
          default: ;
        endcase
      end

      // The output register reloads in the cycle its last beat leaves.
      if (state == S_PUBLISH && (!rv || result.ready)) begin
        rv <= 1'b1;
      end else if (result.valid && result.ready) begin
        rv <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            flag_b <= 1'b0;
            flag_s <= 1'b0;
            if (item.operation == OP_LOAD) begin
              pos[0] <= item.load_pos_x;
              pos[1] <= item.load_pos_y;
              pos[2] <= item.load_pos_z;
              vel[0] <= item.load_vel_x;
              vel[1] <= item.load_vel_y;
              vel[2] <= item.load_vel_z;
              flag_d <= 1'b0;
              state  <= S_PUBLISH;
            end else begin
              for (int i = 0; i < 3; i++) begin
                m[i]    <= mc[i];
                dneg[i] <= dc[i][VEL_W-1];
              end
              l1     <= l1c;
              den    <= '0;
              idx    <= '0;
              flag_d <= (l1c == '0);
              state  <= (l1c == '0) ? S_PUBLISH : S_SQ;
            end
          end
        end
        S_SQ: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (mul_done) begin
            launched <= 1'b0;
            den      <= den + mul_p;
            idx      <= idx + 1'b1;
            if (idx == 2'd2) state <= S_DEN;
          end
        end
        S_DEN: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (mul_done) begin
            launched <= 1'b0;
            den      <= mul_p;
            state    <= S_GT;
          end
        end
        S_GT: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (mul_done) begin
            launched <= 1'b0;
            gt       <= mul_p;
            idx      <= '0;
            state    <= S_NUM;
          end
        end
        S_NUM: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (mul_done) begin
            launched <= 1'b0;
            num      <= mul_p << NUM_SHIFT;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (div_done) begin
            launched <= 1'b0;
            nv[idx]  <= vel_sat(vsum);
            flag_s   <= flag_s | vel_ovf(vsum);
            if (idx == 2'd2) begin
              idx   <= '0;
              state <= S_POS;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_NUM;
            end
          end
        end
        S_POS: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (mul_done) begin
            launched <= 1'b0;
            np[idx]  <= pos_sat(psum);
            flag_s   <= flag_s | pos_ovf(psum);
            if (idx == 2'd2) begin
              // The y position was written back on the previous pass.
              idx   <= 2'd1;
              state <= (np[1] < surf) ? S_BNC : S_FINISH;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_BNC: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (mul_done) begin
            launched <= 1'b0;
            nv[1]    <= vel_sat(bval);
            flag_s   <= flag_s | vel_ovf(bval);
            flag_b   <= 1'b1;
            state    <= S_FINISH;
          end
        end
        S_FINISH: begin
          for (int i = 0; i < 3; i++) begin
            pos[i] <= np[i];
            vel[i] <= nv[i];
          end
          state <= S_PUBLISH;
        end
        S_PUBLISH: begin
          if (!rv || result.ready) begin
            for (int i = 0; i < 3; i++) begin
              out_pos[i] <= pos[i];
              out_vel[i] <= vel[i];
            end
            out_b <= flag_b;
            out_d <= flag_d;
            out_s <= flag_s;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign result.valid      = rv;
  assign result.pos_x      = out_pos[0];
  assign result.pos_y      = out_pos[1];
  assign result.pos_z      = out_pos[2];
  assign result.vel_x      = out_vel[0];
  assign result.vel_y      = out_vel[1];
  assign result.vel_z      = out_vel[2];
  assign result.bounced    = out_b;
  assign result.degenerate = out_d;
  assign result.saturated  = out_s;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.degenerate && (result.bounced || result.saturated)))
    else $error("degenerate step reported with bounce or clamp");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("second beat taken while a step is in progress");

  a_commit_publish: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |=> (state == S_PUBLISH))
    else $error("committed state not published");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for point_gravity_euler_step: a queue-fed driver and a
// monitor compare every result beat with a bit-exact prediction of the body.
// ----------------------------------------------------------------------------
module tb import pge_pkg::*; ();

  typedef struct packed {
    logic                    operation;
    logic signed [POS_W-1:0] px, py, pz;
    logic signed [VEL_W-1:0] vx, vy, vz;
  } body_cmd_t;

  typedef struct packed {
    logic signed [POS_W-1:0] px, py, pz;
    logic signed [VEL_W-1:0] vx, vy, vz;
    logic                    bounced, degenerate, saturated;
  } body_state_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  pge_in_if  item ();
  pge_out_if result ();

  point_gravity_euler_step dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .item(item.sink), .result(result.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted body state and attractor settings.
  logic signed [POS_W-1:0] body_p [3];
  logic signed [VEL_W-1:0] body_v [3];
  logic signed [POS_W-1:0] att [3];
  logic [GM_W-1:0]         gm;
  logic [STEP_W-1:0]       dt;
  logic signed [POS_W-1:0] surface;
  logic [REST_W-1:0]       rest;

  body_cmd_t   pending_cmds [$];
  body_state_t expected_states [$];
  int          failures = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_on = 1'b0;
  int          hold_cnt = 0;
  bit          clamp_hit;

  function automatic longint clamp_w(longint x, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) begin
      clamp_hit = 1'b1;
      return hi;
    end
    if (x < lo) begin
      clamp_hit = 1'b1;
      return lo;
    end
    return x;
  endfunction

  function automatic logic [63:0] magnitude(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic body_state_t advance_body(body_cmd_t c);
    body_state_t s;
    longint d [3], nv [3], np [3];
    logic [63:0] m [3], l1, dv, dp, bp;
    logic [255:0] den, num, q;
    logic [127:0] t;
    bit bounce;
    bounce = 1'b0;
    clamp_hit = 1'b0;
    if (c.operation == OP_LOAD) begin
      body_p[0] = c.px; body_p[1] = c.py; body_p[2] = c.pz;
      body_v[0] = c.vx; body_v[1] = c.vy; body_v[2] = c.vz;
    end else begin
      l1 = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = longint'(att[i]) - longint'(body_p[i]);
        m[i] = magnitude(d[i]);
        l1 += m[i];
      end
      if (l1 == 0) begin
        s = {body_p[0], body_p[1], body_p[2], body_v[0], body_v[1], body_v[2],
             3'b010};
        return s;
      end
      den = 256'(m[0]) * m[0] + 256'(m[1]) * m[1] + 256'(m[2]) * m[2];
      den = den * l1;
      for (int i = 0; i < 3; i++) begin
        num = ((256'(gm) * m[i]) * dt) << 32;
        q = num / den;
        dv = (q > (256'(1) << 46)) ? (64'(1) << 46) : q[63:0];
        nv[i] = clamp_w(longint'(body_v[i]) + (d[i] < 0 ? -longint'(dv) : longint'(dv)),
                        VEL_W);
      end
      for (int i = 0; i < 3; i++) begin
        t = (128'(magnitude(nv[i])) * dt) >> 32;
        dp = (t > (128'(1) << 60)) ? (64'(1) << 60) : t[63:0];
        np[i] = clamp_w(longint'(body_p[i]) + (nv[i] < 0 ? -longint'(dp) : longint'(dp)),
                        POS_W);
      end
      if (np[1] < longint'(surface)) begin
        bp = (magnitude(nv[1]) * rest) >> REST_BITS;
        nv[1] = clamp_w(nv[1] < 0 ? longint'(bp) : -longint'(bp), VEL_W);
        bounce = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        body_p[i] = np[i][POS_W-1:0];
        body_v[i] = nv[i][VEL_W-1:0];
      end
    end
    s = {body_p[0], body_p[1], body_p[2], body_v[0], body_v[1], body_v[2],
         bounce, 1'b0, (c.operation == OP_LOAD) ? 1'b0 : clamp_hit};
    return s;
  endfunction

  // Driver: one beat offered at a time, next beat chosen once the last is taken.
  always @(posedge clk) begin
    if (rst) begin
      item.valid      <= 1'b0;
      item.operation  <= OP_TICK;
      item.load_pos_x <= '0;
      item.load_pos_y <= '0;
      item.load_pos_z <= '0;
      item.load_vel_x <= '0;
      item.load_vel_y <= '0;
      item.load_vel_z <= '0;
    end else begin
      if (item.valid && item.ready) begin
        expected_states.push_back(advance_body({item.operation, item.load_pos_x,
          item.load_pos_y, item.load_pos_z, item.load_vel_x, item.load_vel_y,
          item.load_vel_z}));
      end
      if (!item.valid || item.ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
          body_cmd_t c;
          c = pending_cmds.pop_front();
          item.valid      <= 1'b1;
          item.operation  <= c.operation;
          item.load_pos_x <= c.px;
          item.load_pos_y <= c.py;
          item.load_pos_z <= c.pz;
          item.load_vel_x <= c.vx;
          item.load_vel_y <= c.vy;
          item.load_vel_z <= c.vz;
        end else begin
          item.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the block backs up into its input.
  always @(posedge clk) begin
    if (hold_on && hold_cnt < 5000) hold_cnt <= hold_cnt + 1;
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_states.size() == 0) begin
          $error("result beat with no expected state");
          failures++;
        end else begin
          body_state_t e;
          e = expected_states.pop_front();
          check_field("pos_x", e.px, result.pos_x);
          check_field("pos_y", e.py, result.pos_y);
          check_field("pos_z", e.pz, result.pos_z);
          check_field("vel_x", e.vx, result.vel_x);
          check_field("vel_y", e.vy, result.vel_y);
          check_field("vel_z", e.vz, result.vel_z);
          check_field("bounced", e.bounced, result.bounced);
          check_field("degenerate", e.degenerate, result.degenerate);
          check_field("saturated", e.saturated, result.saturated);
        end
      end
      result.ready <= !(hold_on && hold_cnt < 5000) && ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic longint rand_span(int w);
    logic [63:0] raw;
    int bits;
    longint v;
    raw = {$urandom, $urandom};
    bits = $urandom_range(w, 1);
    if (bits == w) begin
      v = longint'(raw << (64 - w)) >>> (64 - w);
    end else begin
      v = longint'(raw & ((64'(1) << bits) - 1));
      if ($urandom_range(1)) v = -v;
    end
    return v;
  endfunction

  function automatic body_cmd_t load_cmd(longint x, longint y, longint z,
                                         longint a, longint b, longint c);
    body_cmd_t k;
    k.operation = OP_LOAD;
    k.px = x[POS_W-1:0]; k.py = y[POS_W-1:0]; k.pz = z[POS_W-1:0];
    k.vx = a[VEL_W-1:0]; k.vy = b[VEL_W-1:0]; k.vz = c[VEL_W-1:0];
    return k;
  endfunction

  function automatic body_cmd_t noise_cmd();
    body_cmd_t k;
    logic [287:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    k = raw[$bits(body_cmd_t)-1:0];
    return k;
  endfunction

  function automatic body_cmd_t tick_cmd();
    body_cmd_t k;
    k = noise_cmd();
    k.operation = OP_TICK;
    return k;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_ATT_X:   att[0] = value[POS_W-1:0];
      REG_ATT_Y:   att[1] = value[POS_W-1:0];
      REG_ATT_Z:   att[2] = value[POS_W-1:0];
      REG_GM:      gm = value[GM_W-1:0];
      REG_STEP:    dt = value[STEP_W-1:0];
      REG_SURFACE: surface = value[POS_W-1:0];
      default:     rest = value[REST_W-1:0];
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_cmds.size() > 0 || item.valid || expected_states.size() > 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_setting(int p);
    logic [CFG_W-1:0] pmax, pmin, r;
    pmax = CFG_W'(POS_MAX64);
    pmin = CFG_W'(POS_MIN64);
    case (p)
      1: begin
        write_reg(REG_ATT_X, CFG_W'(rand_span(30)));
        write_reg(REG_ATT_Y, CFG_W'(rand_span(30)));
        write_reg(REG_ATT_Z, CFG_W'(rand_span(30)));
        write_reg(REG_GM, {GM_W{1'b1}});
        write_reg(REG_STEP, CFG_W'(25'd16777216));
        write_reg(REG_SURFACE, pmin);
        write_reg(REG_REST, CFG_W'(17'd65536));
      end
      2: begin
        write_reg(REG_ATT_X, pmin);
        write_reg(REG_ATT_Y, pmin);
        write_reg(REG_ATT_Z, pmin);
        write_reg(REG_GM, '0);
        write_reg(REG_STEP, '0);
        write_reg(REG_SURFACE, pmax);
        write_reg(REG_REST, '0);
      end
      3: begin
        write_reg(REG_ATT_X, pmax);
        write_reg(REG_ATT_Y, pmax);
        write_reg(REG_ATT_Z, pmax);
        write_reg(REG_GM, CFG_W'({$urandom, $urandom}));
        write_reg(REG_STEP, CFG_W'($urandom_range(2000000)));
        write_reg(REG_SURFACE, CFG_W'(rand_span(POS_W)));
        write_reg(REG_REST, CFG_W'($urandom_range(65536)));
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          r = CFG_W'(rand_span(40));
          write_reg(cfg_reg_t'(i), r);
        end
        write_reg(REG_GM, CFG_W'({$urandom, $urandom} >> $urandom_range(12)));
        write_reg(REG_STEP, CFG_W'($urandom_range(16777216)));
        write_reg(REG_SURFACE, CFG_W'(rand_span(38)));
        write_reg(REG_REST, CFG_W'($urandom_range(65536, 30000)));
      end
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Well-formed runs: a load somewhere around the attractor or the surface,
  // then a few ticks; the rest is raw noise.
  task automatic queue_random(int count);
    int n;
    longint ox, oy, oz;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 85) begin
        ox = att[0] + rand_span(POS_W - 2);
        oy = ($urandom_range(2) == 0) ? surface + rand_span(24) : att[1] + rand_span(POS_W - 2);
        oz = att[2] + rand_span(POS_W - 2);
        if ($urandom_range(19) == 0) begin
          ox = att[0]; oy = att[1]; oz = att[2];
        end
        pending_cmds.push_back(load_cmd(clamp_w(ox, POS_W), clamp_w(oy, POS_W),
          clamp_w(oz, POS_W), rand_span(VEL_W), rand_span(VEL_W), rand_span(VEL_W)));
        n++;
        repeat ($urandom_range(6, 1)) begin
          pending_cmds.push_back(tick_cmd());
          n++;
        end
      end else begin
        pending_cmds.push_back(noise_cmd());
        n++;
      end
    end
  endtask

  initial begin
    att[0] = 44'sd65536000; att[1] = '0; att[2] = '0;
    gm = 52'd398576057600000;
    dt = 25'd335544;
    surface = 44'sd417529856000;
    rest = 17'd58982;
    body_p[0] = '0; body_p[1] = 44'sd417536409600; body_p[2] = '0;
    body_v[0] = '0; body_v[1] = '0; body_v[2] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      send_idle = (p < 2) ? 30 : (p < 4) ? 67 : 0;
      recv_idle = (p < 2) ? 67 : (p < 4) ? 30 : 0;
      if (p > 0) apply_setting(p);
      if (p == 0) begin
        // Ticks from the reset state, extremes, the zero-distance case and a bounce.
        pending_cmds.push_back(tick_cmd());
        pending_cmds.push_back(tick_cmd());
        pending_cmds.push_back(load_cmd(POS_MAX64, POS_MAX64, POS_MAX64,
                                        VEL_MAX64, VEL_MAX64, VEL_MAX64));
        pending_cmds.push_back(tick_cmd());
        pending_cmds.push_back(load_cmd(POS_MIN64, POS_MIN64, POS_MIN64,
                                        VEL_MIN64, VEL_MIN64, VEL_MIN64));
        pending_cmds.push_back(tick_cmd());
        pending_cmds.push_back(load_cmd(att[0], att[1], att[2], 5, -7, 9));
        pending_cmds.push_back(tick_cmd());
        pending_cmds.push_back(load_cmd(0, surface - 1, 0, 0, -64'sd100000000, 0));
        pending_cmds.push_back(tick_cmd());
        pending_cmds.push_back(load_cmd(0, surface + 10, 0, 0, VEL_MIN64, 0));
        pending_cmds.push_back(tick_cmd());
        pending_cmds.push_back(load_cmd(att[0] + 1, att[1], att[2], 0, 0, 0));
        pending_cmds.push_back(tick_cmd());
        pending_cmds.push_back(load_cmd(att[0], att[1] - 1, att[2] + 1, 0, 0, 0));
        pending_cmds.push_back(tick_cmd());
        pending_cmds.push_back(load_cmd(0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(tick_cmd());
      end
      if (p == 4) hold_on = 1'b1;
      queue_random(310);
      wait_idle();
    end

    repeat (2000) @(posedge clk);
    if (failures == 0) begin
      $display("point_gravity_euler_step verification clean");
    end else begin
      $display("point_gravity_euler_step verification failed");
    end
    $finish;
  end

  initial begin
    #120_000_000;
    $display("point_gravity_euler_step verification failed");
    $finish;
  end

endmodule
